// ----- src/lvc_pkg.sv -----
// Shared types, constants and helper functions for the LRU key-value cache.
package lvc_pkg;

   localparam int ENTRIES = 16;
   localparam int KEY_BITS = 16;
   localparam int KEY_W = 16;
   localparam int VALUE_W = 32;
   localparam int CAP_W = 5;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0] count_type;

   // Result of the parallel key search over the valid slots.
   typedef struct packed {
      logic hit;
      logic [ENTRIES-1:0] upto_hit;
      value_type hit_value;
   } lookup_type;

   // Reduce the key field to the bits that are stored and compared.
   function automatic key_type fold_key(input logic [KEY_W-1:0] k);
      key_type r;
      r = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         if (i < KEY_W) begin
            r[i] = k[i];
         end
      end
      return r;
   endfunction

   // Clamp a written capacity into the range 1 to ENTRIES.
   function automatic count_type sat_capacity(input logic [CAP_W-1:0] w);
      count_type r;
      if (w == '0) begin
         r = count_type'(1);
      end else if (int'(w) > ENTRIES) begin
         r = count_type'(ENTRIES);
      end else begin
         r = count_type'(w);
      end
      return r;
   endfunction

endpackage

// ----- src/lvc_req_if.sv -----
// Request channel: valid/ready handshake carrying one get or put beat.
interface lvc_req_if import lvc_pkg::*; ();
   logic valid;
   logic ready;
   logic req_type;
   logic [KEY_W-1:0] key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, req_type, key, value, input ready);
   modport sink (input valid, req_type, key, value, output ready);
   modport monitor (input valid, ready, req_type, key, value);
endinterface

// ----- src/lvc_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one lookup result beat.
interface lvc_rsp_if import lvc_pkg::*; ();
   logic valid;
   logic ready;
   logic found;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink (input valid, found, read_value, output ready);
   modport monitor (input valid, ready, found, read_value);
endinterface

// ----- src/lvc_lookup.sv -----
// Parallel key compare across the valid slots with first-hit selection.
module lvc_lookup import lvc_pkg::*; (
   input  key_type    key,
   input  key_type    slot_keys [ENTRIES],
   input  value_type  slot_values [ENTRIES],
   input  count_type  count,
   output lookup_type result
);

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] first;
   logic               taken;
   logic               above;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (count_type'(i) < count) && (slot_keys[i] == key);
      end
   end

   // Keep only the lowest matching slot, the most recent copy.
   always_comb begin
      taken = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         first[i] = match[i] && !taken;
         taken = taken || match[i];
      end
   end

   always_comb begin
      result.hit = |match;
      result.hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (first[i]) begin
            result.hit_value = slot_values[i];
         end
      end
      // Slot i lies at or above the hit slot when the hit is at i or deeper.
      above = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         above = above || first[i];
         result.upto_hit[i] = above;
      end
   end

endmodule

// ----- src/lvc_store.sv -----
// Recency-ordered slot registers and occupancy count, updated once per beat.
module lvc_store import lvc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       upd,
   input  logic       req_type,
   input  key_type    key,
   input  value_type  value,
   input  lookup_type lk,
   input  count_type  cap,
   output key_type    slot_keys [ENTRIES],
   output value_type  slot_values [ENTRIES],
   output count_type  count
);

   key_type   keys_ff [ENTRIES];
   value_type values_ff [ENTRIES];
   count_type count_ff;
   count_type count_in;
   logic      is_put;
   logic      shift_all;

   assign is_put = (req_type == REQ_PUT);
   assign shift_all = is_put && !lk.hit;

   // A put that hits keeps occupancy (clipped to capacity); a put that misses
   // drops to capacity-1 if needed and then adds one entry.
   always_comb begin
      count_in = count_ff;
      if (is_put) begin
         if (lk.hit) begin
            count_in = (count_ff >= cap) ? cap : count_ff;
         end else begin
            count_in = ((count_ff >= cap) ? (cap - count_type'(1)) : count_ff)
                       + count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (upd) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd && (is_put || lk.hit)) begin
         keys_ff[0] <= key;
         values_ff[0] <= is_put ? value : lk.hit_value;
      end
      for (int i = 1; i < ENTRIES; i++) begin
         if (upd && (shift_all || lk.upto_hit[i])) begin
            keys_ff[i] <= keys_ff[i-1];
            values_ff[i] <= values_ff[i-1];
         end
      end
   end

   assign slot_keys = keys_ff;
   assign slot_values = values_ff;
   assign count = count_ff;

endmodule

// ----- src/lru_key_value_cache.sv -----
// Top level of the fully associative key-value cache with LRU replacement.
//
// Usage: requests enter on req_ch, one get or put per beat with a key and a
// value. Every request produces exactly one response beat on rsp_ch, in
// request order: found tells whether the key was held before the request,
// and read_value carries the stored value on a get hit and zero otherwise.
// The csr_we/csr_wdata port writes the capacity register; zero counts as
// one and values above the slot count saturate. Write it only while idle.
//
// Flow: a request beat accepted into the request register is looked up there,
// and the store is updated as its response is loaded into the response register.
// Throughput: one request per cycle while rsp_ch is not stalled, because the
// whole key search and the one-step recency shift fit between the request
// register and the response register, and the store is updated in the same cycle.
//
// Reset clears the occupancy count, both channel registers and restores the
// capacity to its default. When the receiver stalls rsp_ch, the response
// register holds its beat and one more request may wait in the request
// register; after that req_ch.ready drops until the response is taken.
module lru_key_value_cache import lvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   lvc_req_if.sink          req_ch,
   lvc_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   // Request register.
   logic      in_valid_ff;
   logic      in_type_ff;
   key_type   in_key_ff;
   value_type in_value_ff;

   // Response register.
   logic      out_valid_ff;
   logic      out_found_ff;
   value_type out_value_ff;

   // Effective capacity, already clamped into 1..ENTRIES.
   count_type cap_ff;

   logic       out_free;
   logic       fire;
   key_type    slot_keys [ENTRIES];
   value_type  slot_values [ENTRIES];
   count_type  count;
   lookup_type lk;

   // The response register frees up when it is empty or its beat is taken;
   // the request held in front of it is then processed in this cycle.
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign fire = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= count_type'(CAP_RESET);
      end else if (csr_we) begin
         cap_ff <= sat_capacity(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_type_ff <= req_ch.req_type;
         in_key_ff <= fold_key(req_ch.key);
         in_value_ff <= req_ch.value;
      end
   end

   lvc_lookup u_lookup (
      .key         (in_key_ff),
      .slot_keys   (slot_keys),
      .slot_values (slot_values),
      .count       (count),
      .result      (lk)
   );

   lvc_store u_store (
      .clock       (clock),
      .reset       (reset),
      .upd         (fire),
      .req_type    (in_type_ff),
      .key         (in_key_ff),
      .value       (in_value_ff),
      .lk          (lk),
      .cap         (cap_ff),
      .slot_keys   (slot_keys),
      .slot_values (slot_values),
      .count       (count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // A put reports whether the key existed but never returns a value.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_found_ff <= lk.hit;
         out_value_ff <= (in_type_ff == REQ_GET && lk.hit) ? lk.hit_value : '0;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.found = out_found_ff;
   assign rsp_ch.read_value = out_value_ff;

endmodule

// ----- src/lvc_checker.sv -----
// Port-level checks for the LRU key-value cache, bound to the top level.
module lvc_checker import lvc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic signed [VALUE_W-1:0] rsp_read_value
);

   // A stalled response beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_found) && $stable(rsp_read_value))
      else $error("response beat changed while stalled");

   // Requests are refused only when a response is stuck and one is queued.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without downstream stall");

   // A miss never carries a value.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_value == '0)
      else $error("miss response with nonzero value");

   // No response beat right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind lru_key_value_cache lvc_checker u_lvc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_found      (rsp_ch.found),
   .rsp_read_value (rsp_ch.read_value)
);
